// ===== rtl/sphere_collision_detect_assert.svh =====
// assertion macros used by the sphere collision detect top level rtl
// expects signals named clock and reset in the including module
`ifndef SPHERE_COLLISION_DETECT_ASSERT_SVH
`define SPHERE_COLLISION_DETECT_ASSERT_SVH

// property must hold at every clock edge out of reset
`define SCD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sphere_collision_detect: check failed");

// consequent must hold in the same cycle as the antecedent
`define SCD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sphere_collision_detect: implication failed");

`endif

// ===== rtl/scd_pkg.sv =====
// shared types and constants for the sphere collision detect pipeline
// no dependencies
`default_nettype none

package scd_pkg;

   localparam int POS_W   = 24;
   localparam int RAD_W   = 23;
   localparam int EPS_W   = 52;
   localparam int MAG_W   = 25;
   localparam int DIST2_W = 50;
   localparam int RAD2_W  = 64;
   localparam int ROOT_W  = 32;
   localparam int NUM_W   = 47;
   localparam int QUO_W   = 16;
   localparam int NORM_W  = 16;
   localparam int REQ_W   = 192;
   localparam int RSP_W   = 72;

   localparam logic [NORM_W-1:0] NORM_ONE = 16'd16384;

   // side data carried alongside the square root
   typedef struct packed {
      logic             hit;
      logic             coinc;
      logic [RAD_W-1:0] radius_a;
      logic [POS_W-1:0] rsum;
      logic [2:0]       neg;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [MAG_W-1:0] mag_z;
   } side_type;

   // side data carried alongside the normal divide
   typedef struct packed {
      logic             hit;
      logic             coinc;
      logic [RAD_W-1:0] radius_a;
      logic [POS_W-1:0] pen;
      logic [2:0]       neg;
   } div_side_type;

endpackage

`default_nettype wire

// ===== rtl/sphere_collision_detect.sv =====
// Sphere pair contact test. One transaction per clock is taken while the result side does
// not stall, and one result is returned per transaction, in order. The pipeline runs
// through the distance stages, the 32-stage square root of the squared distance and the
// 16-stage divider that forms the normal. When the result side stalls, the whole pipeline
// holds and one transaction is parked in an input skid register, and input acceptance
// resumes once it has entered the pipeline. csr_wr_data sets the coincidence threshold.
// depends on scd_pkg, scd_dist, scd_sqrt, scd_div and the assertion macro header
`default_nettype none
`include "sphere_collision_detect_assert.svh"

module sphere_collision_detect (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [scd_pkg::EPS_W-1:0]   csr_wr_data,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, radius_a, radius_b, zero pad
   input  wire logic [scd_pkg::REQ_W-1:0]   req_tdata,
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   // penetration, normal_x, normal_y, normal_z
   output      logic [scd_pkg::RSP_W-1:0]   rsp_tdata,
   // hit
   output      logic                        rsp_tuser
);
   import scd_pkg::*;

   logic [EPS_W-1:0]    eps_val_ff;
   logic                en;
   logic                acc;
   logic                skid_full_ff, skid_full_in;
   logic [REQ_W-1:0]    skid_data_ff;
   logic                req_tready_ff;
   logic                pipe_valid;
   logic [REQ_W-1:0]    pipe_data;

   logic                d_valid;
   logic [DIST2_W-1:0]  d_dist2;
   side_type            d_side;

   logic                s_valid;
   logic [ROOT_W-1:0]   s_root;
   side_type            s_side;

   logic [24:0]         root_int;
   logic [2:0][NUM_W-1:0] num;
   div_side_type        dv_side_in;

   logic                q_valid;
   logic [2:0][QUO_W-1:0] q_quo;
   div_side_type        q_side;

   logic [NORM_W-1:0]   norm_mag [0:2];
   logic [NORM_W-1:0]   norm_val [0:2];
   logic [POS_W-1:0]    pen_in;
   logic [NORM_W-1:0]   nx_in, ny_in, nz_in;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [RSP_W-1:0]    rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_val_ff <= EPS_W'(17);
      end else if (csr_wr_en) begin
         eps_val_ff <= csr_wr_data;
      end
   end

   assign en  = !rsp_valid_ff || rsp_tready;
   assign acc = req_tvalid && req_tready_ff;

   always_comb begin
      skid_full_in = skid_full_ff;
      if (en) begin
         skid_full_in = 1'b0;
      end else if (acc) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff  <= 1'b0;
         req_tready_ff <= 1'b0;
      end else begin
         skid_full_ff  <= skid_full_in;
         req_tready_ff <= !skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && acc) begin
         skid_data_ff <= req_tdata;
      end
   end

   assign pipe_valid = skid_full_ff || acc;
   assign pipe_data  = skid_full_ff ? skid_data_ff : req_tdata;

   scd_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pipe_valid),
      .pos_a_x   (pipe_data[23:0]),
      .pos_a_y   (pipe_data[47:24]),
      .pos_a_z   (pipe_data[71:48]),
      .pos_b_x   (pipe_data[95:72]),
      .pos_b_y   (pipe_data[119:96]),
      .pos_b_z   (pipe_data[143:120]),
      .radius_a  (pipe_data[166:144]),
      .radius_b  (pipe_data[189:167]),
      .eps       (eps_val_ff),
      .out_valid (d_valid),
      .out_dist2 (d_dist2),
      .out_side  (d_side)
   );

   scd_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (d_valid),
      .in_radicand ({d_dist2, 14'd0}),
      .in_side     (d_side),
      .out_valid   (s_valid),
      .out_root    (s_root),
      .out_side    (s_side)
   );

   always_comb begin
      root_int = s_root[ROOT_W-1:7];
      num[0] = {1'b0, s_side.mag_x, 21'd0} + {16'd0, s_root[ROOT_W-1:1]};
      num[1] = {1'b0, s_side.mag_y, 21'd0} + {16'd0, s_root[ROOT_W-1:1]};
      num[2] = {1'b0, s_side.mag_z, 21'd0} + {16'd0, s_root[ROOT_W-1:1]};
      dv_side_in.hit      = s_side.hit;
      dv_side_in.coinc    = s_side.coinc;
      dv_side_in.radius_a = s_side.radius_a;
      dv_side_in.pen      = s_side.rsum - root_int[POS_W-1:0];
      dv_side_in.neg      = s_side.neg;
   end

   scd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_num    (num),
      .in_den    (s_root),
      .in_side   (dv_side_in),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_side  (q_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         norm_mag[i] = (q_quo[i] > NORM_ONE) ? NORM_ONE : q_quo[i];
         norm_val[i] = q_side.neg[i] ? (~norm_mag[i] + 16'd1) : norm_mag[i];
      end
      pen_in = '0;
      nx_in  = '0;
      ny_in  = '0;
      nz_in  = '0;
      if (q_side.hit && q_side.coinc) begin
         pen_in = {1'b0, q_side.radius_a};
         ny_in  = NORM_ONE;
      end else if (q_side.hit) begin
         pen_in = q_side.pen;
         nx_in  = norm_val[0];
         ny_in  = norm_val[1];
         nz_in  = norm_val[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff  <= q_side.hit;
         rsp_data_ff <= {nz_in, ny_in, nx_in, pen_in};
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // a miss carries all-zero data
   `SCD_ASSERT_IMPL(a_miss_zero, rsp_valid_ff && !rsp_hit_ff, rsp_data_ff == '0)
   // the x normal stays within plus or minus one in q2.14
   `SCD_ASSERT_IMPL(a_norm_x_range, rsp_valid_ff,
      $signed(rsp_data_ff[39:24]) <= 16384 && $signed(rsp_data_ff[39:24]) >= -16384)
   // a parked transaction blocks new input until the pipeline moves
   `SCD_ASSERT_IMPL(a_skid_block, skid_full_ff, !acc)
   // the threshold holds its last written value
   `SCD_ASSERT(a_eps_hold, !csr_wr_en |=> $stable(eps_val_ff))

endmodule

`default_nettype wire

// ===== rtl/scd_dist.sv =====
// difference, squaring and contact test, three register stages
// depends on scd_pkg
`default_nettype none

module scd_dist (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic [scd_pkg::POS_W-1:0]    pos_a_x,
   input  wire logic [scd_pkg::POS_W-1:0]    pos_a_y,
   input  wire logic [scd_pkg::POS_W-1:0]    pos_a_z,
   input  wire logic [scd_pkg::POS_W-1:0]    pos_b_x,
   input  wire logic [scd_pkg::POS_W-1:0]    pos_b_y,
   input  wire logic [scd_pkg::POS_W-1:0]    pos_b_z,
   input  wire logic [scd_pkg::RAD_W-1:0]    radius_a,
   input  wire logic [scd_pkg::RAD_W-1:0]    radius_b,
   input  wire logic [scd_pkg::EPS_W-1:0]    eps,
   output      logic                         out_valid,
   output      logic [scd_pkg::DIST2_W-1:0]  out_dist2,
   output      scd_pkg::side_type            out_side
);
   import scd_pkg::*;

   logic [MAG_W-1:0]   diff [0:2];
   logic [MAG_W-1:0]   mag_in [0:2];
   logic [POS_W-1:0]   rsum_in;

   logic               v1_ff, v2_ff, v3_ff;
   logic [2:0]         neg1_ff, neg2_ff;
   logic [MAG_W-1:0]   mag1_ff [0:2];
   logic [MAG_W-1:0]   mag2_ff [0:2];
   logic [POS_W-1:0]   rsum1_ff, rsum2_ff;
   logic [RAD_W-1:0]   ra1_ff, ra2_ff;
   logic [DIST2_W-1:0] sq2_ff [0:2];
   logic [47:0]        rsq2_ff;

   logic [DIST2_W-1:0] dist2_in;
   logic               hit_in, coinc_in;
   logic [DIST2_W-1:0] dist2_ff;
   side_type           side_ff;

   always_comb begin
      diff[0] = {pos_b_x[POS_W-1], pos_b_x} - {pos_a_x[POS_W-1], pos_a_x};
      diff[1] = {pos_b_y[POS_W-1], pos_b_y} - {pos_a_y[POS_W-1], pos_a_y};
      diff[2] = {pos_b_z[POS_W-1], pos_b_z} - {pos_a_z[POS_W-1], pos_a_z};
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = diff[i][MAG_W-1] ? (~diff[i] + 25'd1) : diff[i];
      end
      rsum_in = {1'b0, radius_a} + {1'b0, radius_b};
   end

   always_comb begin
      dist2_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      hit_in   = dist2_in <= {2'b00, rsq2_ff};
      coinc_in = (dist2_in == '0) || ({2'b00, dist2_in} < eps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= {diff[2][MAG_W-1], diff[1][MAG_W-1], diff[0][MAG_W-1]};
         rsum1_ff <= rsum_in;
         ra1_ff   <= radius_a;
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag_in[i];
            mag2_ff[i] <= mag1_ff[i];
            sq2_ff[i]  <= mag1_ff[i] * mag1_ff[i];
         end
         neg2_ff  <= neg1_ff;
         rsum2_ff <= rsum1_ff;
         ra2_ff   <= ra1_ff;
         rsq2_ff  <= rsum1_ff * rsum1_ff;
         dist2_ff         <= dist2_in;
         side_ff.hit      <= hit_in;
         side_ff.coinc    <= coinc_in;
         side_ff.radius_a <= ra2_ff;
         side_ff.rsum     <= rsum2_ff;
         side_ff.neg      <= neg2_ff;
         side_ff.mag_x    <= mag2_ff[0];
         side_ff.mag_y    <= mag2_ff[1];
         side_ff.mag_z    <= mag2_ff[2];
      end
   end

   assign out_valid = v3_ff;
   assign out_dist2 = dist2_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== rtl/scd_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on scd_pkg
`default_nettype none

module scd_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [scd_pkg::RAD2_W-1:0]  in_radicand,
   input  wire scd_pkg::side_type           in_side,
   output      logic                        out_valid,
   output      logic [scd_pkg::ROOT_W-1:0]  out_root,
   output      scd_pkg::side_type           out_side
);
   import scd_pkg::*;

   logic                v_ff    [0:ROOT_W];
   side_type            side_ff [0:ROOT_W];
   logic [RAD2_W-1:0]   rad_ff  [0:ROOT_W];
   logic [ROOT_W+1:0]   rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]   root_ff [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         rad_ff[0]  <= in_radicand;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [ROOT_W+3:0] part;
      logic [ROOT_W+3:0] trial;
      logic [ROOT_W+3:0] dif;
      logic              take;
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         part    = {rem_ff[k], rad_ff[k][RAD2_W-1 -: 2]};
         trial   = {2'b00, root_ff[k], 2'b01};
         dif     = part - trial;
         take    = part >= trial;
         rem_in  = take ? dif[ROOT_W+1:0] : part[ROOT_W+1:0];
         root_in = {root_ff[k][ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            rad_ff[k+1]  <= {rad_ff[k][RAD2_W-3:0], 2'b00};
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

`default_nettype wire

// ===== rtl/scd_div.sv =====
// pipelined restoring divider, three lanes sharing one divisor
// depends on scd_pkg
`default_nettype none

module scd_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic [2:0][scd_pkg::NUM_W-1:0]       in_num,
   input  wire logic [scd_pkg::ROOT_W-1:0]           in_den,
   input  wire scd_pkg::div_side_type                in_side,
   output      logic                                 out_valid,
   output      logic [2:0][scd_pkg::QUO_W-1:0]       out_quo,
   output      scd_pkg::div_side_type                out_side
);
   import scd_pkg::*;

   logic                     v_ff    [0:QUO_W];
   div_side_type             side_ff [0:QUO_W];
   logic [ROOT_W-1:0]        den_ff  [0:QUO_W];
   logic [2:0][NUM_W-1:0]    rem_ff  [0:QUO_W];
   logic [2:0][QUO_W-1:0]    quo_ff  [0:QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         den_ff[0]  <= in_den;
         rem_ff[0]  <= in_num;
         quo_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [NUM_W:0]        sub;
      logic [NUM_W:0]        wide [0:2];
      logic [NUM_W:0]        dif  [0:2];
      logic [2:0]            take;
      logic [2:0][NUM_W-1:0] rem_in;
      logic [2:0][QUO_W-1:0] quo_in;

      always_comb begin
         sub = {{QUO_W{1'b0}}, den_ff[k]} << (QUO_W - 1 - k);
         for (int i = 0; i < 3; i++) begin
            wide[i]   = {1'b0, rem_ff[k][i]};
            dif[i]    = wide[i] - sub;
            take[i]   = wide[i] >= sub;
            rem_in[i] = take[i] ? dif[i][NUM_W-1:0] : rem_ff[k][i];
            quo_in[i] = {quo_ff[k][i][QUO_W-2:0], take[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            den_ff[k+1]  <= den_ff[k];
            rem_ff[k+1]  <= rem_in;
            quo_ff[k+1]  <= quo_in;
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

`default_nettype wire

// ===== tb/sphere_collision_detect_tb.sv =====
// self-checking testbench for sphere_collision_detect: drives sphere pairs on the
// request stream, predicts each contact result and compares it on the response stream
// depends on scd_pkg and the sphere_collision_detect rtl
`timescale 1ns / 1ps

module sphere_collision_detect_tb;
   import scd_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0] ax, ay, az, bx, by, bz;
      logic [RAD_W-1:0]        ra, rb;
   } pair_type;

   typedef struct {
      logic              hit;
      logic [POS_W-1:0]  pen;
      logic [NORM_W-1:0] nx, ny, nz;
   } contact_type;

   class contact_board_type;
      contact_type               pending[$];
      logic [EPS_W-1:0]          eps_sq = 52'd17;
      int                        errors = 0;
      int                        checked = 0;
      int                        hits = 0;
      int                        coinc = 0;

      function longint unsigned root(longint unsigned n);
         longint unsigned r = 0;
         longint unsigned b = 64'h4000_0000_0000_0000;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [NORM_W-1:0] unit_comp(longint d, longint unsigned q);
         longint unsigned m;
         longint unsigned n;
         m = d < 0 ? -d : d;
         n = ((m << 21) + (q >> 1)) / q;
         if (n > 16384) n = 16384;
         return d < 0 ? NORM_W'(-n) : NORM_W'(n);
      endfunction

      function void note_pair(pair_type p);
         contact_type e;
         longint dx, dy, dz;
         longint unsigned d2, rs, q;
         dx = longint'(p.bx) - longint'(p.ax);
         dy = longint'(p.by) - longint'(p.ay);
         dz = longint'(p.bz) - longint'(p.az);
         d2 = dx * dx + dy * dy + dz * dz;
         rs = longint'(p.ra) + longint'(p.rb);
         e = '{1'b0, '0, '0, '0, '0};
         if (d2 <= rs * rs) begin
            e.hit = 1'b1;
            hits++;
            if (d2 == 0 || d2 < eps_sq) begin
               e.pen = POS_W'(p.ra);
               e.ny = NORM_ONE;
               coinc++;
            end else begin
               q = root(d2 << 14);
               e.pen = POS_W'(rs - root(d2));
               e.nx = unit_comp(dx, q);
               e.ny = unit_comp(dy, q);
               e.nz = unit_comp(dz, q);
            end
         end
         pending.push_back(e);
      endfunction

      function void check_contact(logic [RSP_W-1:0] data, logic user);
         contact_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction: data %h hit %b", data, user);
            return;
         end
         e = pending.pop_front();
         if (user !== e.hit || data[23:0] !== e.pen || data[39:24] !== e.nx
             || data[55:40] !== e.ny || data[71:56] !== e.nz) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp hit %b pen %h n %h %h %h, got hit %b pen %h n %h %h %h",
                  e.hit, e.pen, e.nx, e.ny, e.nz, user, data[23:0], data[39:24],
                  data[55:40], data[71:56]);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [EPS_W-1:0]  csr_wr_data = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;

   contact_board_type board = new();
   int  gap_max = 18;
   int  idle_cycles = 0;
   bit  rx_run = 1'b0;

   sphere_collision_detect dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 3000) begin
            $display("watchdog expired with %0d results pending", board.pending.size());
            $display("sphere_collision_detect test failed");
            $finish;
         end
      end
   end

   // response side, with one long hold-off to back up the pipeline
   initial begin
      int w;
      wait (rx_run);
      forever begin
         w = (board.checked == 300) ? 400 : $urandom_range(0, gap_max);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_contact(rsp_tdata, rsp_tuser);
      end
   end

   task automatic send_pair(pair_type p);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {2'b00, p.rb, p.ra, p.bz, p.by, p.bx, p.az, p.ay, p.ax};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_pair(p);
   endtask

   task automatic write_eps(logic [EPS_W-1:0] v);
      req_tvalid <= 1'b0;
      wait (board.pending.size() == 0);
      @(posedge clock);
      repeat (60) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.eps_sq = v;
   endtask

   function automatic logic signed [POS_W-1:0] jitter(int s);
      return POS_W'($signed($urandom_range(0, (1 << s) * 2)) - (1 << s));
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int kind, s;
      kind = $urandom_range(0, 9);
      s = $urandom_range(0, 22);
      p.ax = POS_W'($urandom); p.ay = POS_W'($urandom); p.az = POS_W'($urandom);
      p.ra = RAD_W'($urandom); p.rb = RAD_W'($urandom);
      if (kind < 2) begin
         p.bx = POS_W'($urandom); p.by = POS_W'($urandom); p.bz = POS_W'($urandom);
      end else begin
         if (kind == 8) s = $urandom_range(0, 3);
         if (kind == 9) s = 0;
         p.bx = POS_W'(p.ax + (kind == 9 ? 0 : jitter(s)));
         p.by = POS_W'(p.ay + (kind == 9 ? 0 : jitter(s)));
         p.bz = POS_W'(p.az + (kind == 9 ? 0 : jitter(s)));
         p.ra = p.ra & RAD_W'((1 << (s + 1)) - 1);
         p.rb = p.rb & RAD_W'((1 << (s + 1)) - 1);
      end
      return p;
   endfunction

   function automatic pair_type mk(int ax, int ay, int az, int bx, int by, int bz,
                                   int ra, int rb);
      pair_type p;
      p.ax = POS_W'(ax); p.ay = POS_W'(ay); p.az = POS_W'(az);
      p.bx = POS_W'(bx); p.by = POS_W'(by); p.bz = POS_W'(bz);
      p.ra = RAD_W'(ra); p.rb = RAD_W'(rb);
      return p;
   endfunction

   initial begin
      pair_type dir[$];
      logic [EPS_W-1:0] eps_set[5];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      rx_run = 1'b1;

      // directed: extremes, axis normals, exact touch, coincident centres
      dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
      dir.push_back(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                       8388607, 8388607));
      dir.push_back(mk(5, -7, 9, 5, -7, 9, 8388607, 8388607));
      dir.push_back(mk(-8388608, 0, 0, 8388607, 0, 0, 8388607, 8388607));
      dir.push_back(mk(100, 0, 0, 4196, 0, 0, 2048, 2048));
      dir.push_back(mk(100, 0, 0, 4197, 0, 0, 2048, 2048));
      dir.push_back(mk(0, 4096, 0, 0, 0, 0, 4096, 1));
      dir.push_back(mk(0, 0, -300, 0, 0, 300, 500, 500));
      dir.push_back(mk(0, 0, 0, 3, 0, 0, 9, 9));
      dir.push_back(mk(0, 0, 0, 1, 1, 1, 0, 2));
      dir.push_back(mk(1000, 2000, 3000, 1700, 1300, 3900, 2000, 2500));
      dir.push_back(mk(-5000, 8000, -12000, -9000, 11000, -7000, 8388607, 0));
      dir.push_back(mk(8388607, -8388608, 8388607, 8388607, -8388608, 8388607, 0, 0));
      dir.push_back(mk(0, 0, 0, -4096, -4096, -4096, 4096, 4096));
      foreach (dir[i]) send_pair(dir[i]);

      eps_set = '{52'd0, {EPS_W{1'b1}}, 52'd1 << 20, 52'd17, 52'd0};
      eps_set[4] = {$urandom, $urandom} & 52'hF_FFFF_FFFF;
      for (int ph = 0; ph < 5; ph++) begin
         write_eps(eps_set[ph]);
         gap_max = (ph == 3) ? 0 : 18;
         repeat (180) send_pair(random_pair());
      end
      req_tvalid <= 1'b0;

      wait (board.pending.size() == 0);
      repeat (60) @(posedge clock);
      $display("%0d sphere pairs checked, %0d contacts, %0d with coincident centres",
               board.checked, board.hits, board.coinc);
      $display("five threshold settings incl. zero and full scale, %0d errors", board.errors);
      if (board.errors == 0)
         $display("sphere_collision_detect test passed");
      else
         $display("sphere_collision_detect test failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/scd_pkg.sv
rtl/scd_dist.sv
rtl/scd_sqrt.sv
rtl/scd_div.sv
rtl/sphere_collision_detect.sv
tb/sphere_collision_detect_tb.sv
